>>> rtl/mtg_pkg.sv
// mtg_pkg: shared types and constants of the mt19937 generator
// no dependencies
package mtg_pkg;
  localparam int unsigned N_WORDS  = 624;
  localparam int unsigned M_OFFSET = 397;
  localparam int unsigned AW       = 10;

  localparam logic [31:0] MUL_SEED  = 32'd1812433253;
  localparam logic [31:0] MUL_PASS1 = 32'd1664525;
  localparam logic [31:0] MUL_PASS2 = 32'd1566083941;
  localparam logic [31:0] ARR_SEED  = 32'd19650218;
  localparam logic [31:0] TOP_BIT   = 32'h80000000;
  localparam logic [31:0] TWIDDLE   = 32'h9908b0df;

  typedef enum logic [1:0] {
    FN_DRAW  = 2'd0,
    FN_SEED  = 2'd1,
    FN_KEY   = 2'd2,
    FN_ARRAY = 2'd3
  } func_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_GEN_RD0,   // read word k
    ST_GEN_RD1,   // read word k+1
    ST_GEN_RD2,   // read word k+m
    ST_GEN_WR,
    ST_DRAW_RD,
    ST_DRAW_OUT,
    ST_SEED_WR0,
    ST_SEED_MUL,
    ST_SEED_WR,
    ST_AP_RDP,    // read previous word
    ST_AP_RDC,    // read current word
    ST_AP_MUL,
    ST_AP_WR,
    ST_AP_WRAP,   // copy last word into word zero
    ST_AP_TOP,
    ST_RESULT
  } state_e;

  // datapath operation selects
  typedef enum logic [3:0] {
    OP_NONE,
    OP_RD_I,      // read address i
    OP_RD_IP,     // read address i-1
    OP_RD_K1,     // read address i+1 (wrapped)
    OP_RD_KM,     // read address i+m (wrapped)
    OP_RD_LAST,   // read the last word
    OP_RD_POS,    // read the word at the draw position
    OP_GEN_WR,    // write regenerated word at i
    OP_SEED_W0,   // write seed at 0
    OP_SEED_MUL,  // register product of prev word
    OP_SEED_WR,   // write product + i at i
    OP_AP_MUL,
    OP_AP_WR,
    OP_WR0_LAST,  // write held word at 0
    OP_WR0_TOP
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       pass2;     // second array pass
    logic       seed_arr;  // seed from array constant
    logic       clr_i;     // i <= 0
    logic       set_i1;    // i <= 1
    logic       inc_i;
    logic       clr_j;
    logic       inc_j;
    logic       clr_pos;
    logic       set_pos_n;
    logic       inc_pos;
    logic       load_cnt1; // cnt <= max(n, len)
    logic       load_cnt2; // cnt <= n-1
    logic       dec_cnt;
    logic       key_wr;
    logic       out_draw;  // latch tempered word as result
    logic       out_zero;
  } dp_cmd_t;

  typedef struct packed {
    logic pos_full;
    logic i_last;      // i == n-1
    logic cnt_one;
  } dp_sts_t;

  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & 32'h9d2c5680);
    y = y ^ ((y << 15) & 32'hefc60000);
    y = y ^ (y >> 18);
    return y;
  endfunction
endpackage

>>> rtl/mtg_ctrl.sv
// mtg_ctrl: sequencer for draw, regenerate, seed, key store and array initialisation
// depends on mtg_pkg
module mtg_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [1:0]       func_i,
  input  mtg_pkg::dp_sts_t sts_i,
  input  logic             out_free_i,
  output logic             busy_o,
  output logic             res_valid_o,
  output mtg_pkg::dp_cmd_t cmd_o
);
  import mtg_pkg::*;

  state_e state_q, state_d;
  logic   arr_q, arr_d;    // seed sequence is part of array init
  logic   p2_q, p2_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      arr_q   <= 1'b0;
      p2_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      arr_q   <= arr_d;
      p2_q    <= p2_d;
    end
  end

  always_comb begin
    state_d = state_q;
    arr_d   = arr_q;
    p2_d    = p2_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          unique case (func_e'(func_i))
            FN_DRAW:  state_d = sts_i.pos_full ? ST_GEN_RD0 : ST_DRAW_RD;
            FN_SEED:  begin state_d = ST_SEED_WR0; arr_d = 1'b0; end
            FN_KEY:   state_d = ST_RESULT;
            FN_ARRAY: begin state_d = ST_SEED_WR0; arr_d = 1'b1; end
            default:  state_d = ST_RESULT;
          endcase
        end
      end
      ST_GEN_RD0:  state_d = ST_GEN_RD1;
      ST_GEN_RD1:  state_d = ST_GEN_RD2;
      ST_GEN_RD2:  state_d = ST_GEN_WR;
      ST_GEN_WR:   state_d = sts_i.i_last ? ST_DRAW_RD : ST_GEN_RD0;
      ST_DRAW_RD:  state_d = ST_DRAW_OUT;
      ST_DRAW_OUT: state_d = ST_RESULT;
      ST_SEED_WR0: state_d = ST_SEED_MUL;
      ST_SEED_MUL: state_d = ST_SEED_WR;
      ST_SEED_WR: begin
        if (!sts_i.i_last) begin
          state_d = ST_SEED_MUL;
        end else if (arr_q) begin
          state_d = ST_AP_RDP;
          p2_d    = 1'b0;
        end else begin
          state_d = ST_RESULT;
        end
      end
      ST_AP_RDP: state_d = ST_AP_RDC;
      ST_AP_RDC: state_d = ST_AP_MUL;
      ST_AP_MUL: state_d = ST_AP_WR;
      ST_AP_WR: begin
        if (sts_i.i_last) begin
          state_d = ST_AP_WRAP;
        end else if (sts_i.cnt_one) begin
          if (p2_q) state_d = ST_AP_TOP;
          else begin state_d = ST_AP_RDP; p2_d = 1'b1; end
        end else begin
          state_d = ST_AP_RDP;
        end
      end
      ST_AP_WRAP: begin
        if (sts_i.cnt_one) begin
          if (p2_q) state_d = ST_AP_TOP;
          else begin state_d = ST_AP_RDP; p2_d = 1'b1; end
        end else begin
          state_d = ST_AP_RDP;
        end
      end
      ST_AP_TOP: state_d = ST_RESULT;
      ST_RESULT: if (out_free_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.op    = OP_NONE;
    cmd_o.pass2 = p2_q;
    busy_o      = (state_q != ST_IDLE);
    res_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          unique case (func_e'(func_i))
            FN_DRAW: begin
              if (sts_i.pos_full) cmd_o.clr_i = 1'b1;
            end
            FN_SEED:  cmd_o.out_zero = 1'b1;
            FN_KEY: begin
              cmd_o.key_wr   = 1'b1;
              cmd_o.out_zero = 1'b1;
            end
            FN_ARRAY: begin
              cmd_o.out_zero = 1'b1;
              cmd_o.seed_arr = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_GEN_RD0: cmd_o.op = OP_RD_I;
      ST_GEN_RD1: cmd_o.op = OP_RD_K1;
      ST_GEN_RD2: cmd_o.op = OP_RD_KM;
      ST_GEN_WR: begin
        cmd_o.op    = OP_GEN_WR;
        cmd_o.inc_i = 1'b1;
        if (sts_i.i_last) cmd_o.clr_pos = 1'b1;
      end
      ST_DRAW_RD: cmd_o.op = OP_RD_POS;
      ST_DRAW_OUT: begin
        cmd_o.out_draw = 1'b1;
        cmd_o.inc_pos  = 1'b1;
      end
      ST_SEED_WR0: begin
        cmd_o.op     = OP_SEED_W0;
        cmd_o.set_i1 = 1'b1;
      end
      ST_SEED_MUL: cmd_o.op = OP_SEED_MUL;
      ST_SEED_WR: begin
        cmd_o.op    = OP_SEED_WR;
        cmd_o.inc_i = 1'b1;
        if (sts_i.i_last) begin
          cmd_o.set_pos_n = 1'b1;
          cmd_o.set_i1    = 1'b1;
          cmd_o.clr_j     = 1'b1;
          cmd_o.load_cnt1 = 1'b1;
        end
      end
      ST_AP_RDP: cmd_o.op = OP_RD_IP;
      ST_AP_RDC: cmd_o.op = OP_RD_I;
      ST_AP_MUL: cmd_o.op = OP_AP_MUL;
      ST_AP_WR: begin
        cmd_o.op    = OP_AP_WR;
        cmd_o.inc_j = ~p2_q;
        if (sts_i.i_last) begin
          cmd_o.set_i1 = 1'b1;
        end else begin
          cmd_o.inc_i   = 1'b1;
          cmd_o.dec_cnt = ~sts_i.cnt_one;
          if (sts_i.cnt_one && !p2_q) cmd_o.load_cnt2 = 1'b1;
        end
      end
      ST_AP_WRAP: begin
        cmd_o.op      = OP_WR0_LAST;
        cmd_o.dec_cnt = ~sts_i.cnt_one;
        if (sts_i.cnt_one && !p2_q) cmd_o.load_cnt2 = 1'b1;
      end
      ST_AP_TOP: cmd_o.op = OP_WR0_TOP;
      ST_RESULT: res_valid_o = 1'b1;
      default: ;
    endcase
  end
endmodule

>>> rtl/mtg_datapath.sv
// mtg_datapath: state memory, key store, index counters, multiplier and output word
// depends on mtg_pkg
module mtg_datapath #(
  parameter int unsigned KEY_WORDS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mtg_pkg::dp_cmd_t     cmd_i,
  input  logic [31:0]          value_i,
  input  logic [3:0]           key_slot_i,
  input  logic [4:0]           key_length_i,
  output mtg_pkg::dp_sts_t     sts_o,
  output logic [31:0]          word_o
);
  import mtg_pkg::*;

  localparam int unsigned KW = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
  localparam int unsigned CW = 11;

  logic [31:0] mem [N_WORDS];
  logic [31:0] key_mem [KEY_WORDS];

  logic [AW-1:0] i_q, pos_q;
  logic [KW-1:0] j_q;
  logic [CW-1:0] cnt_q;
  logic [31:0]   rd_q, a_q, b_q, c_q, prod_q, key_q, word_q;

  // the previous word arrives one read ahead of the current one
  logic [31:0] px_q, pxs_w_hold;

  // effective key length, clamped to 1..KEY_WORDS
  logic [10:0] len_w;
  always_comb begin
    if (key_length_i == 5'd0) len_w = 11'd1;
    else if (11'(key_length_i) > 11'(KEY_WORDS)) len_w = 11'(KEY_WORDS);
    else len_w = 11'(key_length_i);
  end

  logic [AW-1:0] i1_w, im_w, ip_w, rd_addr;
  logic          rd_en, wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data, mix_w, pxs_w, seed_w;

  assign i1_w = (i_q == AW'(N_WORDS - 1)) ? '0 : i_q + 1'b1;
  assign im_w = (i_q >= AW'(N_WORDS - M_OFFSET)) ? i_q - AW'(N_WORDS - M_OFFSET)
                                                  : i_q + AW'(M_OFFSET);
  assign ip_w = i_q - 1'b1;

  assign seed_w = cmd_i.seed_arr ? ARR_SEED : value_i;

  always_comb begin
    mix_w = ((a_q & TOP_BIT) | (b_q & ~TOP_BIT)) >> 1;
    if (b_q[0]) mix_w = mix_w ^ TWIDDLE;
  end

  assign pxs_w = rd_q ^ (rd_q >> 30);
  assign pxs_w_hold = px_q * (cmd_i.pass2 ? MUL_PASS2 : MUL_PASS1);

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = i_q;
    wr_en   = 1'b0;
    wr_addr = i_q;
    wr_data = prod_q;
    unique case (cmd_i.op)
      OP_RD_I:    rd_addr = i_q;
      OP_RD_IP:   rd_addr = ip_w;
      OP_RD_K1:   rd_addr = i1_w;
      OP_RD_KM:   rd_addr = im_w;
      OP_RD_LAST: rd_addr = AW'(N_WORDS - 1);
      OP_RD_POS:  rd_addr = pos_q;
      OP_GEN_WR: begin
        wr_en = 1'b1; wr_data = rd_q ^ mix_w;
      end
      OP_SEED_W0: begin
        wr_en = 1'b1; wr_addr = '0; wr_data = c_q;
      end
      OP_SEED_WR: begin
        wr_en = 1'b1; wr_data = prod_q + 32'(i_q);
      end
      OP_AP_WR: begin
        wr_en = 1'b1;
        if (cmd_i.pass2) wr_data = (rd_q ^ prod_q) - 32'(i_q);
        else             wr_data = (rd_q ^ prod_q) + key_q + 32'(j_q);
      end
      OP_WR0_LAST: begin
        wr_en = 1'b1; wr_addr = '0; wr_data = c_q;
      end
      OP_WR0_TOP: begin
        wr_en = 1'b1; wr_addr = '0; wr_data = TOP_BIT;
      end
      default: rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
    if (cmd_i.key_wr && (32'(key_slot_i) < 32'(KEY_WORDS)))
      key_mem[KW'(key_slot_i)] <= value_i;
    key_q <= key_mem[j_q];
  end

  // operand and product registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_RD_K1) a_q <= rd_q;
    if (cmd_i.op == OP_RD_KM) b_q <= rd_q;
    if (cmd_i.seed_arr || cmd_i.out_zero) c_q <= seed_w;
    if (cmd_i.op == OP_SEED_WR) c_q <= prod_q + 32'(i_q);
    if (cmd_i.op == OP_AP_WR && i_q == AW'(N_WORDS - 1)) c_q <= wr_data;
    if (cmd_i.op == OP_SEED_MUL) begin
      prod_q <= MUL_SEED * (c_q ^ (c_q >> 30));
    end
    if (cmd_i.op == OP_AP_MUL) prod_q <= pxs_w_hold;
    if (cmd_i.op == OP_RD_I) px_q <= pxs_w;
    if (cmd_i.out_draw) word_q <= temper(rd_q);
    else if (cmd_i.out_zero) word_q <= '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q   <= '0;
      j_q   <= '0;
      pos_q <= AW'(N_WORDS);
      cnt_q <= '0;
    end else begin
      if (cmd_i.clr_i)       i_q <= '0;
      else if (cmd_i.set_i1) i_q <= AW'(1);
      else if (cmd_i.inc_i)  i_q <= i_q + 1'b1;
      if (cmd_i.clr_j) j_q <= '0;
      else if (cmd_i.inc_j) j_q <= (11'(j_q) + 11'd1 >= len_w) ? '0 : j_q + 1'b1;
      if (cmd_i.clr_pos)        pos_q <= '0;
      else if (cmd_i.set_pos_n) pos_q <= AW'(N_WORDS);
      else if (cmd_i.inc_pos)   pos_q <= pos_q + 1'b1;
      if (cmd_i.load_cnt1)
        cnt_q <= (len_w > 11'(N_WORDS)) ? CW'(len_w) : CW'(N_WORDS);
      else if (cmd_i.load_cnt2) cnt_q <= CW'(N_WORDS - 1);
      else if (cmd_i.dec_cnt)   cnt_q <= cnt_q - 1'b1;
    end
  end

  assign sts_o.pos_full = (pos_q >= AW'(N_WORDS));
  assign sts_o.i_last   = (i_q == AW'(N_WORDS - 1));
  assign sts_o.cnt_one  = (cnt_q == CW'(1));
  assign word_o         = word_q;
endmodule

>>> rtl/mersenne_twister_generator.sv
// mersenne_twister_generator: mt19937 generator top level
// depends on mtg_pkg, mtg_ctrl, mtg_datapath
//
// channel  dir  signals                     contents (low bit up)
// s_axis   in   tvalid tready tdata[39:0]   func[1:0] value[33:2] key_slot[37:34]
// m_axis   out  tvalid tready tdata[31:0]   random_word; tuser = is_draw
// cfg      in   cfg_we_i cfg_wdata_i[4:0]   key_length
//
// draw: the tempered word at the draw position; once all words are drawn, as on
// the first draw after seeding, the state is first regenerated word by word. seed
// by value: word zero, then each word from its predecessor; array seeding: that
// seed sequence, then two passes that each read the previous and current word,
// multiply and write. one item at a time; tready is low while an item is in work
// or its result waits. reset clears control only; state words are undefined
module mersenne_twister_generator #(
  parameter int unsigned KEY_WORDS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // func, value, key_slot
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // random_word
  output logic        m_axis_tuser,   // is_draw
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i
);
  import mtg_pkg::*;

  logic [4:0] key_len_q;
  logic       draw_q;
  logic       busy, res_valid, start;
  dp_cmd_t    cmd;
  dp_sts_t    sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q <= 5'd1;
      draw_q    <= 1'b0;
    end else begin
      if (cfg_we_i) key_len_q <= cfg_wdata_i;
      if (start) draw_q <= (s_axis_tdata[1:0] == FN_DRAW);
    end
  end

  assign s_axis_tready = ~busy;
  assign start         = s_axis_tvalid & ~busy;

  mtg_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .start_i     (start),
    .func_i      (s_axis_tdata[1:0]),
    .sts_i       (sts),
    .out_free_i  (m_axis_tready),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .cmd_o       (cmd)
  );

  mtg_datapath #(.KEY_WORDS(KEY_WORDS)) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i        (cmd),
    .value_i      (s_axis_tdata[33:2]),
    .key_slot_i   (s_axis_tdata[37:34]),
    .key_length_i (key_len_q),
    .sts_o        (sts),
    .word_o       (m_axis_tdata)
  );

  assign m_axis_tvalid = res_valid;
  assign m_axis_tuser  = draw_q;
endmodule
